>>> sv/mtpc_pkg.sv
`timescale 1ns / 1ps

package mtpc_pkg;

  // sequence lengths of the two pattern types
  localparam int unsigned WalkSteps = 100;
  localparam int unsigned FillSteps = 256;

  // walking sequence landmarks
  localparam logic [6:0] PosZero      = 7'd0;
  localparam logic [6:0] PosAlt       = 7'd1;
  localparam logic [6:0] PosWalkStart = 7'd3;
  localparam logic [6:0] PosFillStart = 7'd35;
  localparam logic [6:0] PosShiftOut  = 7'd67;
  localparam logic [6:0] PosLast      = 7'(WalkSteps - 1);

  localparam logic [31:0] WordAlt  = 32'h5555_5555;
  localparam logic [31:0] WordOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] WordOne  = 32'h0000_0001;

  localparam logic       PatWalk = 1'b0;
  localparam logic       PatFill = 1'b1;

  typedef enum logic [2:0] {
    OP_RESET   = 3'd0,
    OP_BEGIN   = 3'd1,
    OP_GEN     = 3'd2,
    OP_VERIFY  = 3'd3,
    OP_NEXT    = 3'd4,
    OP_SET_PAT = 3'd5
  } op_e;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  mismatches;
    logic [31:0] error_total;
    logic        more;
    logic [7:0]  test_number;
    logic        pattern_now;
  } result_t;

  // test index folded into the walking sequence (value below three times its length)
  function automatic logic [6:0] walk_mod(input logic [7:0] v);
    logic [7:0] r;
    begin
      r = v;
      if (r >= 8'(2 * WalkSteps)) begin
        r = r - 8'(2 * WalkSteps);
      end else if (r >= 8'(WalkSteps)) begin
        r = r - 8'(WalkSteps);
      end
      return r[6:0];
    end
  endfunction

endpackage

>>> sv/mtpc_core.sv
`timescale 1ns / 1ps

module mtpc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [2:0]            op_i,
  input  logic [31:0]           data_word_i,
  input  logic                  pattern_i,
  output mtpc_pkg::result_t     result_o
);
  import mtpc_pkg::*;

  logic [7:0]  test_q, test_d;
  logic        pat_q, pat_d;
  logic [6:0]  pos_q, pos_d;
  logic [31:0] run_q, run_d;
  logic [31:0] err_q, err_d;

  logic [31:0] walk_word;
  logic [31:0] fill_word;
  logic [31:0] word;
  logic [2:0]  mis;
  logic        more;
  logic [32:0] err_sum;
  logic [8:0]  next_idx;
  logic [8:0]  idx_count;

  // walking word at the current position
  always_comb begin
    if (pos_q == PosZero) begin
      walk_word = '0;
    end else if (pos_q == PosAlt) begin
      walk_word = WordAlt;
    end else if (pos_q == PosWalkStart || pos_q == PosFillStart) begin
      walk_word = WordOne;
    end else if (pos_q == PosLast) begin
      walk_word = WordOnes;
    end else if (pos_q < PosFillStart) begin
      walk_word = {run_q[30:0], 1'b0};
    end else if (pos_q < PosShiftOut) begin
      walk_word = {run_q[30:0], 1'b1};
    end else begin
      walk_word = {run_q[30:0], 1'b0};
    end
  end

  assign fill_word = {4{test_q}};
  assign next_idx  = {1'b0, test_q} + 9'd1;
  assign idx_count = (pat_q == PatWalk) ? 9'(WalkSteps) : 9'(FillSteps);

  // per-op state update and result
  always_comb begin
    test_d  = test_q;
    pat_d   = pat_q;
    pos_d   = pos_q;
    run_d   = run_q;
    err_d   = err_q;
    word    = '0;
    mis     = '0;
    more    = 1'b0;
    err_sum = '0;
    case (op_e'(op_i))
      OP_RESET: begin
        test_d = '0;
        pat_d  = PatWalk;
        pos_d  = '0;
        run_d  = '0;
        err_d  = '0;
      end
      OP_BEGIN: begin
        pos_d = walk_mod(test_q);
        run_d = '0;
        err_d = '0;
      end
      OP_GEN, OP_VERIFY: begin
        if (pat_q == PatWalk) begin
          word  = walk_word;
          run_d = walk_word;
          pos_d = (pos_q == PosLast) ? PosZero : pos_q + 7'd1;
          if (op_e'(op_i) == OP_VERIFY && data_word_i != walk_word) begin
            mis = 3'd1;
          end
        end else begin
          word = fill_word;
          if (op_e'(op_i) == OP_VERIFY) begin
            for (int k = 0; k < 4; k++) begin
              if (data_word_i[8*k +: 8] != test_q) begin
                mis = mis + 3'd1;
              end
            end
          end
        end
        // saturating error total
        err_sum = {1'b0, err_q} + 33'(mis);
        err_d   = err_sum[32] ? WordOnes : err_sum[31:0];
      end
      OP_NEXT: begin
        if (next_idx < idx_count) begin
          test_d = next_idx[7:0];
          more   = 1'b1;
        end else begin
          test_d = '0;
          pat_d  = ~pat_q;
          more   = (pat_q == PatWalk);
        end
      end
      OP_SET_PAT: begin
        pat_d  = pattern_i;
        test_d = '0;
      end
      default: begin
      end
    endcase
  end

  // engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_q <= '0;
      pat_q  <= PatWalk;
      pos_q  <= '0;
      run_q  <= '0;
      err_q  <= '0;
    end else if (en_i) begin
      test_q <= test_d;
      pat_q  <= pat_d;
      pos_q  <= pos_d;
      run_q  <= run_d;
      err_q  <= err_d;
    end
  end

  assign result_o.word        = word;
  assign result_o.mismatches  = mis;
  assign result_o.error_total = err_d;
  assign result_o.more        = more;
  assign result_o.test_number = test_d;
  assign result_o.pattern_now = pat_d;

endmodule

>>> sv/memory_test_pattern_checker_unit.sv
// an item is held in the input register, then its result in the result register
// one item per cycle while no held result waits for out_ready_i
// an input register and a result register each hold one item while the output stalls
// reset (rst_ni low, asynchronous) clears test index, pattern type, position,
// running word, error total and both valid flags
`timescale 1ns / 1ps

module memory_test_pattern_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] data_word_i,
  input  logic        pattern_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_o,
  output logic [2:0]  mismatches_o,
  output logic [31:0] error_total_o,
  output logic        more_o,
  output logic [7:0]  test_number_o,
  output logic        pattern_now_o
);
  import mtpc_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [2:0]  op_q;
  logic [31:0] data_q;
  logic        pattern_q;
  logic        out_valid_q, out_valid_d;
  result_t     res_q;
  result_t     res;
  logic        advance;
  logic        take;

  // handshake
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;

  assign in_valid_d  = take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // valid flags of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= op_i;
      data_q    <= data_word_i;
      pattern_q <= pattern_i;
    end
  end

  mtpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .op_i        (op_q),
    .data_word_i (data_q),
    .pattern_i   (pattern_q),
    .result_o    (res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign word_o        = res_q.word;
  assign mismatches_o  = res_q.mismatches;
  assign error_total_o = res_q.error_total;
  assign more_o        = res_q.more;
  assign test_number_o = res_q.test_number;
  assign pattern_now_o = res_q.pattern_now;

`ifndef SYNTH
  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a pending result");

  // walking pattern counts at most one mismatch per word
  a_walk_mis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pattern_now_o == PatWalk && more_o == 1'b0) |->
    (mismatches_o == 3'd0 || mismatches_o == 3'd1))
    else $error("walking mismatch count above one");

  // mismatch counts never exceed the byte count of a word
  a_fill_mis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mismatches_o <= 3'd4))
    else $error("mismatch count above four");

  // walking test index stays inside the sequence
  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pattern_now_o == PatWalk) |-> (test_number_o < 8'(WalkSteps)))
    else $error("walking test index out of range");
`endif

endmodule
